### sv/bde_pkg.sv
`default_nettype none
package bde_pkg;

	localparam int HISTORY_DEPTH = 64;
	localparam int PTR_W = $clog2(HISTORY_DEPTH);
	localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
	localparam int BPM_SCALE = 60000;
	localparam int NUM_W = $clog2(BPM_SCALE * HISTORY_DEPTH);
	localparam int CNT_W = $clog2(NUM_W);

	localparam logic [15:0] THRESHOLD_RST = 16'd19661;
	localparam logic [15:0] HOLDOFF_RST = 16'd500;
	localparam logic [19:0] WINDOW_RST = 20'd10000;

	localparam logic [1:0] REG_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_HOLDOFF = 2'd1;
	localparam logic [1:0] REG_WINDOW = 2'd2;

	typedef enum logic [1:0] {
		PH_READY = 2'd0,
		PH_BEAT = 2'd1,
		PH_HOLD = 2'd2
	} phase_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_PUSH,
		BK_PRUNE_A,
		BK_PRUNE_B,
		BK_TEMPO_A,
		BK_TEMPO_B,
		BK_TEMPO_C,
		BK_DIVIDE,
		BK_DONE
	} back_state_t;

	typedef struct packed {
		logic beat;
		logic [31:0] now_ms;
	} bde_item_t;

endpackage
`default_nettype wire

### sv/bde_front.sv
`default_nettype none
module bde_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic accept,
	input wire logic [15:0] left_level,
	input wire logic [15:0] right_level,
	input wire logic [31:0] now_ms,
	input wire logic [15:0] level_threshold,
	input wire logic [15:0] holdoff_ms,
	output bde_pkg::bde_item_t item
);

	bde_pkg::phase_t phase_q, phase_next, phase_mid;
	logic [31:0] holdoff_start_q, start_next;
	logic [16:0] level_sum;
	logic beat_now;

	assign level_sum = {1'b0, left_level} + {1'b0, right_level};

	// Beat decision and the hold-off test that runs in the same frame.
	always_comb begin
		phase_mid = phase_q;
		start_next = holdoff_start_q;
		unique case (phase_q)
			bde_pkg::PH_READY: begin
				if (level_sum[16:1] >= level_threshold) begin
					phase_mid = bde_pkg::PH_BEAT;
				end
			end
			bde_pkg::PH_BEAT: begin
				phase_mid = bde_pkg::PH_HOLD;
				start_next = now_ms;
			end
			default: phase_mid = phase_q;
		endcase
		phase_next = phase_mid;
		if (phase_mid != bde_pkg::PH_READY && phase_mid != bde_pkg::PH_BEAT &&
			(now_ms - start_next) >= {16'd0, holdoff_ms}) begin
			phase_next = bde_pkg::PH_READY;
		end
	end

	always_comb begin
		beat_now = (phase_q == bde_pkg::PH_READY) && (level_sum[16:1] >= level_threshold);
		item.beat = beat_now;
		item.now_ms = now_ms;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= bde_pkg::PH_READY;
			holdoff_start_q <= '0;
		end else if (accept) begin
			phase_q <= phase_next;
			holdoff_start_q <= start_next;
		end
	end

endmodule
`default_nettype wire

### sv/bde_queue.sv
`default_nettype none
module bde_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr_en,
	input wire bde_pkg::bde_item_t wr_item,
	output logic full,
	input wire logic rd_en,
	output bde_pkg::bde_item_t rd_item,
	output logic not_empty
);

	bde_pkg::bde_item_t slots_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign rd_item = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slots_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, wr_en} - {1'b0, rd_en};
		end
	end

endmodule
`default_nettype wire

### sv/bde_back.sv
`default_nettype none
module bde_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire bde_pkg::bde_item_t in_item,
	output logic in_take,
	input wire logic [19:0] window_ms,
	input wire logic out_pop,
	output logic out_valid,
	output logic out_beat,
	output logic [15:0] out_bpm,
	output logic [6:0] out_count
);

	localparam int P = bde_pkg::PTR_W;
	localparam int F = bde_pkg::FILL_W;
	localparam int N = bde_pkg::NUM_W;

	bde_pkg::back_state_t state_q, state_next;

	logic [31:0] mem [bde_pkg::HISTORY_DEPTH];
	logic [31:0] rdata_q;
	logic [P-1:0] rd_addr, wr_addr;
	logic wr_en;

	logic [P-1:0] head_q;
	logic [F-1:0] fill_q;
	logic beat_q;
	logic [31:0] now_q, oldest_q, span_q;
	logic [32:0] rem_q, trial;
	logic [N-1:0] num_q, quo_q;
	logic [bde_pkg::CNT_W-1:0] cnt_q;
	logic out_valid_q;
	logic prune_hit, fill_full;
	logic [31:0] span_now;

	assign fill_full = (fill_q == F'(bde_pkg::HISTORY_DEPTH));
	assign prune_hit = (fill_q != '0) && ((now_q - rdata_q) > {12'd0, window_ms});
	assign span_now = rdata_q - oldest_q;
	assign trial = {rem_q[31:0], num_q[N-1]};

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			bde_pkg::BK_IDLE: begin
				if (in_valid) begin
					state_next = in_item.beat ? bde_pkg::BK_PUSH : bde_pkg::BK_TEMPO_A;
				end
			end
			bde_pkg::BK_PUSH: state_next = bde_pkg::BK_PRUNE_A;
			bde_pkg::BK_PRUNE_A: state_next = bde_pkg::BK_PRUNE_B;
			bde_pkg::BK_PRUNE_B: begin
				state_next = prune_hit ? bde_pkg::BK_PRUNE_A : bde_pkg::BK_TEMPO_A;
			end
			bde_pkg::BK_TEMPO_A: begin
				state_next = (fill_q < F'(2)) ? bde_pkg::BK_DONE : bde_pkg::BK_TEMPO_B;
			end
			bde_pkg::BK_TEMPO_B: state_next = bde_pkg::BK_TEMPO_C;
			bde_pkg::BK_TEMPO_C: begin
				state_next = (span_now == '0) ? bde_pkg::BK_DONE : bde_pkg::BK_DIVIDE;
			end
			bde_pkg::BK_DIVIDE: begin
				if (cnt_q == '0) begin
					state_next = bde_pkg::BK_DONE;
				end
			end
			bde_pkg::BK_DONE: begin
				if (!out_valid_q) begin
					state_next = bde_pkg::BK_IDLE;
				end
			end
			default: state_next = bde_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		in_take = 1'b0;
		wr_en = 1'b0;
		wr_addr = fill_full ? head_q : head_q + fill_q[P-1:0];
		rd_addr = head_q;
		unique case (state_q)
			bde_pkg::BK_IDLE: in_take = in_valid;
			bde_pkg::BK_PUSH: wr_en = 1'b1;
			bde_pkg::BK_TEMPO_B: rd_addr = head_q + fill_q[P-1:0] - P'(1);
			default: rd_addr = head_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= now_q;
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bde_pkg::BK_IDLE;
			head_q <= '0;
			fill_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (state_q == bde_pkg::BK_PUSH) begin
				if (fill_full) begin
					head_q <= head_q + P'(1);
				end else begin
					fill_q <= fill_q + F'(1);
				end
			end
			if (state_q == bde_pkg::BK_PRUNE_B && prune_hit) begin
				head_q <= head_q + P'(1);
				fill_q <= fill_q - F'(1);
			end
			if (state_q == bde_pkg::BK_DONE && !out_valid_q) begin
				out_valid_q <= 1'b1;
			end else if (out_pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			bde_pkg::BK_IDLE: begin
				beat_q <= in_item.beat;
				now_q <= in_item.now_ms;
			end
			bde_pkg::BK_TEMPO_A: quo_q <= '0;
			bde_pkg::BK_TEMPO_B: oldest_q <= rdata_q;
			bde_pkg::BK_TEMPO_C: begin
				span_q <= span_now;
				rem_q <= '0;
				num_q <= N'(32'(bde_pkg::BPM_SCALE) * 32'(fill_q - F'(1)));
				cnt_q <= bde_pkg::CNT_W'(N - 1);
			end
			bde_pkg::BK_DIVIDE: begin
				if (trial >= {1'b0, span_q}) begin
					rem_q <= trial - {1'b0, span_q};
					quo_q <= {quo_q[N-2:0], 1'b1};
				end else begin
					rem_q <= trial;
					quo_q <= {quo_q[N-2:0], 1'b0};
				end
				num_q <= {num_q[N-2:0], 1'b0};
				cnt_q <= cnt_q - bde_pkg::CNT_W'(1);
			end
			bde_pkg::BK_DONE: begin
				if (!out_valid_q) begin
					out_beat <= beat_q;
					out_bpm <= (quo_q > N'(16'hFFFF)) ? 16'hFFFF : quo_q[15:0];
					out_count <= 7'(fill_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

### sv/beat_detect_bpm_estimator.sv
`default_nettype none
// Beat detector with a tempo estimate in beats per minute.
// Each input item is one analysis frame: the left and right magnitudes of the
// watched spectrum bin and a millisecond timestamp. It is offered with push and
// taken when full is low. Every frame yields exactly one result item: a beat
// flag, the tempo estimate and the number of beat timestamps held in history.
// Results wait in a one-entry output register; empty low means a result is on
// the ports, and pop takes it.
// The front end decides the beat and hold-off phase in the cycle the frame is
// taken and passes it through a two-entry queue to the back end, which keeps a
// 64-entry history memory with one read port. For a frame without a beat the
// back end takes it from the queue, passes three states that read the oldest
// and newest history entries, runs a restoring divider that resolves one
// quotient bit per cycle, and loads the output register. A beat frame adds a
// history write and, for each history entry it examines while pruning, a read
// state and a test state. The back end works on one frame at a time; the input
// side keeps taking frames while the queue has room, and a stalled receiver
// simply holds the back end in its final state. Reset restores the register
// defaults, empties history and queues, and makes the detector ready.
// Registers sit on the APB port at offsets 0, 4, 8.
module beat_detect_bpm_estimator (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire logic [15:0] left_level,
	input wire logic [15:0] right_level,
	input wire logic [31:0] now_ms,
	output logic empty,
	input wire logic pop,
	output logic beat,
	output logic [15:0] bpm_estimate,
	output logic [6:0] history_count,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [3:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	logic [15:0] threshold_q, holdoff_q;
	logic [19:0] window_q;
	logic accept, q_take, q_valid, out_valid, cfg_wr;
	bde_pkg::bde_item_t front_item, q_item;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	// Register file; writes beyond the third register are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= bde_pkg::THRESHOLD_RST;
			holdoff_q <= bde_pkg::HOLDOFF_RST;
			window_q <= bde_pkg::WINDOW_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				bde_pkg::REG_THRESHOLD: threshold_q <= pwdata[15:0];
				bde_pkg::REG_HOLDOFF: holdoff_q <= pwdata[15:0];
				bde_pkg::REG_WINDOW: window_q <= pwdata[19:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			bde_pkg::REG_THRESHOLD: prdata = {16'd0, threshold_q};
			bde_pkg::REG_HOLDOFF: prdata = {16'd0, holdoff_q};
			bde_pkg::REG_WINDOW: prdata = {12'd0, window_q};
			default: prdata = '0;
		endcase
	end

	assign accept = push & ~full;

	bde_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.left_level(left_level),
		.right_level(right_level),
		.now_ms(now_ms),
		.level_threshold(threshold_q),
		.holdoff_ms(holdoff_q),
		.item(front_item)
	);

	bde_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(accept),
		.wr_item(front_item),
		.full(full),
		.rd_en(q_take),
		.rd_item(q_item),
		.not_empty(q_valid)
	);

	bde_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(q_valid),
		.in_item(q_item),
		.in_take(q_take),
		.window_ms(window_q),
		.out_pop(pop & out_valid),
		.out_valid(out_valid),
		.out_beat(beat),
		.out_bpm(bpm_estimate),
		.out_count(history_count)
	);

	assign empty = ~out_valid;

endmodule
`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 1ps
`default_nettype none

module tb_top;

	// One predicted result item: what the detector should report for a frame.
	typedef struct {
		logic beat;
		logic [15:0] bpm;
		logic [6:0] count;
	} frame_result_t;

	// Tempo tracker: keeps its own copy of the detector state and registers,
	// works out the result of every frame that the block takes, and checks the
	// result items as they leave, oldest first.
	class tempo_scoreboard;
		logic [15:0] threshold;
		logic [15:0] holdoff;
		logic [19:0] window;
		bde_pkg::phase_t phase;
		logic [31:0] holdoff_start;
		logic [31:0] beat_times [bde_pkg::HISTORY_DEPTH];
		int head;
		int fill;
		frame_result_t awaited [$];
		int errors;
		int beats;
		int deepest;
		int checked;

		function new();
			threshold = bde_pkg::THRESHOLD_RST;
			holdoff = bde_pkg::HOLDOFF_RST;
			window = bde_pkg::WINDOW_RST;
			phase = bde_pkg::PH_READY;
			holdoff_start = '0;
			head = 0;
			fill = 0;
			errors = 0;
			beats = 0;
			deepest = 0;
			checked = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] value);
			case (idx)
				bde_pkg::REG_THRESHOLD: threshold = value[15:0];
				bde_pkg::REG_HOLDOFF: holdoff = value[15:0];
				bde_pkg::REG_WINDOW: window = value[19:0];
				default: ;
			endcase
		endfunction

		function logic [15:0] tempo();
			logic [31:0] span;
			logic [63:0] q;
			if (fill < 2)
				return 16'd0;
			span = beat_times[(head + fill - 1) % bde_pkg::HISTORY_DEPTH] - beat_times[head];
			if (span == 32'd0)
				return 16'd0;
			q = (64'd60000 * 64'(fill - 1)) / {32'd0, span};
			return (q > 64'd65535) ? 16'hFFFF : q[15:0];
		endfunction

		// Note a frame the block has taken and predict its result item.
		function void note_frame(logic [15:0] l, logic [15:0] r, logic [31:0] t);
			logic [16:0] sum;
			logic [15:0] level;
			logic [31:0] age;
			frame_result_t res;
			sum = {1'b0, l} + {1'b0, r};
			level = sum[16:1];
			res.beat = 1'b0;
			if (phase == bde_pkg::PH_READY && level >= threshold) begin
				res.beat = 1'b1;
				phase = bde_pkg::PH_BEAT;
				beats++;
				if (fill >= bde_pkg::HISTORY_DEPTH) begin
					head = (head + 1) % bde_pkg::HISTORY_DEPTH;
					fill--;
				end
				beat_times[(head + fill) % bde_pkg::HISTORY_DEPTH] = t;
				fill++;
				age = t - beat_times[head];
				while (fill > 0 && age > {12'd0, window}) begin
					head = (head + 1) % bde_pkg::HISTORY_DEPTH;
					fill--;
					age = t - beat_times[head];
				end
			end else if (phase == bde_pkg::PH_BEAT) begin
				phase = bde_pkg::PH_HOLD;
				holdoff_start = t;
			end
			if (phase != bde_pkg::PH_READY && phase != bde_pkg::PH_BEAT &&
				(t - holdoff_start) >= {16'd0, holdoff})
				phase = bde_pkg::PH_READY;
			if (fill > deepest)
				deepest = fill;
			res.bpm = tempo();
			res.count = 7'(fill);
			awaited.push_back(res);
		endfunction

		function void check_result(logic b, logic [15:0] bpm, logic [6:0] cnt);
			frame_result_t e;
			if (awaited.size() == 0) begin
				$display("%0t: unexpected result beat=%0d bpm=%0d count=%0d",
					$time, b, bpm, cnt);
				errors++;
				return;
			end
			e = awaited.pop_front();
			checked++;
			if (b !== e.beat) begin
				$display("%0t: beat expected %0d actual %0d", $time, e.beat, b);
				errors++;
			end
			if (bpm !== e.bpm) begin
				$display("%0t: bpm_estimate expected %0d actual %0d", $time, e.bpm, bpm);
				errors++;
			end
			if (cnt !== e.count) begin
				$display("%0t: history_count expected %0d actual %0d",
					$time, e.count, cnt);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	logic [15:0] left_level;
	logic [15:0] right_level;
	logic [31:0] now_ms;
	logic empty;
	logic pop;
	logic beat;
	logic [15:0] bpm_estimate;
	logic [6:0] history_count;
	logic psel;
	logic penable;
	logic pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	tempo_scoreboard sb = new();

	// Percentages of cycles in which the sender holds back and the receiver stalls.
	int send_idle_pct = 0;
	int pop_stall_pct = 0;
	logic [31:0] clock_ms = 32'd0;
	int quiet_cycles = 0;

	localparam int QUIET_LIMIT = 20000;

	beat_detect_bpm_estimator u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.left_level(left_level),
		.right_level(right_level),
		.now_ms(now_ms),
		.empty(empty),
		.pop(pop),
		.beat(beat),
		.bpm_estimate(bpm_estimate),
		.history_count(history_count),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result side: a result item is taken at an edge where pop is high and empty
	// is low. The values seen here are those from just before the edge.
	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			sb.check_result(beat, bpm_estimate, history_count);
		pop <= ($urandom_range(99) >= pop_stall_pct);
	end

	// Watchdog: any handshake or register access counts as progress.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || psel || !arst_n) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Register write on the APB port: setup cycle, then access cycle. pready is
	// always high, so the write lands at the edge that ends the access cycle.
	// The bus is left selected so that a following write starts its setup cycle
	// at once; set_regs releases it after the last one.
	task automatic reg_write(logic [1:0] idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		sb.write_reg(idx, value);
	endtask

	task automatic set_regs(logic [15:0] thr, logic [15:0] hold, logic [19:0] win);
		reg_write(bde_pkg::REG_THRESHOLD, {16'd0, thr});
		reg_write(bde_pkg::REG_HOLDOFF, {16'd0, hold});
		reg_write(bde_pkg::REG_WINDOW, {12'd0, win});
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Offer one frame and wait until the block takes it. push is left high on
	// return so back-to-back frames need no second assignment in one step.
	task automatic send_frame(logic [15:0] l, logic [15:0] r, logic [31:0] t);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		left_level <= l;
		right_level <= r;
		now_ms <= t;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sb.note_frame(l, r, t);
	endtask

	// Stop offering, let every awaited result come out, then allow the back end
	// its longest pass before the registers may change.
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	// Random frames: time mostly moves forward by a beat-like step, sometimes
	// not at all or by very little (tiny spans, saturation) and now and then
	// jumps anywhere, wrapping the clock. Levels are mostly above the threshold
	// so that the beat, hold-off and ready cycle is exercised over and over.
	task automatic random_frames(int count);
		logic [15:0] l;
		logic [15:0] r;
		int pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 25)
				clock_ms = clock_ms + $urandom_range(3);
			else if (pick < 97)
				clock_ms = clock_ms + $urandom_range(3000);
			else
				clock_ms = $urandom;
			pick = $urandom_range(99);
			if (pick < 50) begin
				l = 16'($urandom_range(65535, sb.threshold));
				r = l;
			end else if (pick < 90) begin
				l = 16'($urandom);
				r = 16'($urandom);
			end else begin
				l = 16'd0;
				r = 16'd0;
			end
			send_frame(l, r, clock_ms);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		left_level = '0;
		right_level = '0;
		now_ms = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames on the reset settings.
		send_frame(16'd0, 16'd0, 32'd100);          // ready, below threshold
		send_frame(16'hFFFF, 16'hFFFF, 32'd200);    // full-scale beat
		send_frame(16'd0, 16'd0, 32'd300);          // beat ends, hold-off begins
		send_frame(16'hFFFF, 16'hFFFF, 32'd500);    // still holding off
		send_frame(16'hFFFF, 16'd0, 32'd800);       // hold-off expires exactly
		send_frame(16'd19661, 16'd19661, 32'd900);  // level exactly on threshold
		send_frame(16'd19660, 16'd19661, 32'd1000); // ends beat
		send_frame(16'd19661, 16'd19660, 32'd2000); // one below threshold
		send_frame(16'd39322, 16'd0, 32'd2100);     // average lands exactly on threshold
		send_frame(16'd0, 16'd0, 32'd2200);
		send_frame(16'hFFFF, 16'hFFFF, 32'd30000);  // hold-off expires, no beat
		send_frame(16'd0, 16'd0, 32'd30100);
		send_frame(16'hFFFF, 16'hFFFF, 32'hFFFF_FF00);
		send_frame(16'd0, 16'd0, 32'hFFFF_FFF0);
		send_frame(16'hFFFF, 16'hFFFF, 32'h0000_0200); // time wraps past zero

		// The sender waits here until every awaited result has come.
		drain();

		// Hold-off of zero, largest window, zero threshold, so every other frame beats:
		// same-time beats give a zero span and tiny spans saturate the estimate.
		set_regs(16'd0, 16'd0, 20'hFFFFF);
		send_frame(16'd1, 16'd0, 32'd5000);
		send_frame(16'd0, 16'd0, 32'd5000);
		send_frame(16'd0, 16'd0, 32'd5000);
		send_frame(16'd0, 16'd0, 32'd5001);
		send_frame(16'd0, 16'd0, 32'd5001);
		send_frame(16'd0, 16'd0, 32'd5002);
		clock_ms = 32'd5002;
		random_frames(140);
		drain();

		// Highest threshold and hold-off, zero window.
		send_idle_pct = 53;
		set_regs(16'hFFFF, 16'hFFFF, 20'd0);
		random_frames(60);
		drain();

		send_idle_pct = 0;
		pop_stall_pct = 53;
		set_regs(16'($urandom), 16'($urandom_range(3000)), 20'($urandom_range(20'hFFFFF)));
		random_frames(100);
		drain();

		send_idle_pct = 8;
		pop_stall_pct = 8;
		set_regs(16'($urandom_range(40000)), 16'($urandom_range(1500)),
			20'($urandom_range(30000)));
		random_frames(100);
		drain();

		$display("Checked %0d result items; %0d beats predicted, history reached %0d entries.",
			sb.checked, sb.beats, sb.deepest);
		$display("Covered threshold, hold-off and window extremes, time wrap and stalls.");
		if (sb.errors == 0 && sb.awaited.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
